@@ hdl/gic_pkg.sv @@
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the gated impulse counter
// Request codes, register indexes, widths and the per-channel control and
// status bundles.
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int GAP_REGS     = 3;
   localparam int LED_BITS     = 3;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 64;
   localparam int CH_W    = 2;
   localparam int TYPE_W  = 2;
   localparam int CSR_W   = 3;
   localparam int CSR_DW  = 32;

   localparam logic [TIME_W-1:0] DEFAULT_GAP_US = 32'd50000;
   localparam logic [TIME_W-1:0] LED_PULSE_US   = 32'd100000;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_SAMPLE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_READ   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_GAP_CH0   = 3'd0;
   localparam logic [CSR_W-1:0] CSR_GAP_CH1   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_GAP_CH2   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_TRIGGER   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_LED_MASK  = 3'd4;

   typedef struct packed {
      logic              step;       // item leaves the input stage this cycle
      logic              sample_sel; // pin sample addressed to this channel
      logic              clear;      // clear all counts
      logic              level;
      logic              trigger;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] gap;        // raw register, zero means default
      logic              led_en;
   } chan_ctl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;     // count after this item
      logic               hit;
      logic               led;       // LED state after this item
   } chan_status_type;

endpackage

@@ hdl/gic_channel.sv @@
// ----------------------------------------------------------------------------
// gic_channel: state and update logic of one counter channel
// Holds count, last level, change time and reference LED timer; presents the
// post-item state combinationally and commits it when the item steps out.
// ----------------------------------------------------------------------------
module gic_channel
   import gic_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  chan_ctl_type    ctl,
   output chan_status_type status
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               level_ff, level_in;
   logic [TIME_W-1:0]  change_ff, change_in;
   logic [TIME_W-1:0]  led_start_ff, led_start_in;
   logic               led_on_ff, led_on_in;

   logic [TIME_W-1:0]  led_age;
   logic [TIME_W-1:0]  since_change;
   logic [TIME_W-1:0]  gap_eff;
   logic               led_alive;
   logic               change;
   logic               hit;

   always_comb begin
      led_age      = ctl.now - led_start_ff;
      since_change = ctl.now - change_ff;
      gap_eff      = (ctl.gap == '0) ? DEFAULT_GAP_US : ctl.gap;
      // expire first, then a new impulse may relight
      led_alive    = led_on_ff && (led_age < LED_PULSE_US);
      change       = ctl.sample_sel && (ctl.level != level_ff);
      hit          = change && (ctl.level == ctl.trigger) && (since_change >= gap_eff);

      count_in     = ctl.clear ? '0 : count_ff + COUNT_W'(hit);
      level_in     = change ? ctl.level : level_ff;
      change_in    = change ? ctl.now : change_ff;
      led_on_in    = (hit && ctl.led_en) ? 1'b1 : led_alive;
      led_start_in = (hit && ctl.led_en) ? ctl.now : led_start_ff;

      status.count = count_in;
      status.hit   = hit;
      status.led   = led_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         level_ff     <= 1'b0;
         change_ff    <= '0;
         led_start_ff <= '0;
         led_on_ff    <= 1'b0;
      end else if (ctl.step) begin
         count_ff     <= count_in;
         level_ff     <= level_in;
         change_ff    <= change_in;
         led_start_ff <= led_start_in;
         led_on_ff    <= led_on_in;
      end
   end

endmodule

@@ hdl/gated_impulse_counter_core.sv @@
// ----------------------------------------------------------------------------
// gated_impulse_counter_core: three-channel impulse counter with minimum gap
// Counts level changes to the trigger level at least a channel's minimum gap
// after its previous change, and pulses its reference LED per count if enabled.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   direction  transfer when
//   -------   -------------------------------------   ---------  -------------------
//   request   req_valid/req_stall, req_type,          in         valid && !stall
//             req_channel, req_pin_level, req_now_us
//   response  rsp_valid/rsp_stall, rsp_count_value,   out        valid && !stall
//             rsp_counted, rsp_channel_ok, rsp_led_lit
//   csr       csr_write_enable, csr_index,            in         write_enable high
//             csr_write_data
//
// One item per clock sustained while rsp_stall stays low. A request is captured
// in the input register, evaluated there against channel state and moved into
// the response register when that register is free; the response is valid once
// it sits in the response register. Channel state commits when the item moves
// into the response register, so the very next item sees it. A response stall
// holds the response register and then the input register; req_stall rises
// only when both are occupied. Synchronous reset clears counts, levels, timers,
// LEDs and loads register defaults.
// ----------------------------------------------------------------------------
module gated_impulse_counter_core
   import gic_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [CH_W-1:0]    req_channel,
   input  logic               req_pin_level,
   input  logic [TIME_W-1:0]  req_now_us,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COUNT_W-1:0] rsp_count_value,
   output logic               rsp_counted,
   output logic               rsp_channel_ok,
   output logic [LED_BITS-1:0] rsp_led_lit,

   input  logic               csr_write_enable,
   input  logic [CSR_W-1:0]   csr_index,
   input  logic [CSR_DW-1:0]  csr_write_data
);

   // configuration registers
   logic [TIME_W-1:0]   gap_ff [GAP_REGS];
   logic                trigger_ff;
   logic [LED_BITS-1:0] led_mask_ff;

   // input stage
   logic               in_valid_ff;
   logic [TYPE_W-1:0]  in_type_ff;
   logic [CH_W-1:0]    in_channel_ff;
   logic               in_level_ff;
   logic [TIME_W-1:0]  in_now_ff;

   // response stage
   logic                rsp_valid_ff;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_counted_ff, rsp_counted_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [LED_BITS-1:0] rsp_led_ff, rsp_led_in;

   logic advance;   // response register free to take the input stage
   logic step;      // input item moves into the response register
   logic req_take;

   chan_ctl_type    ctl    [NUM_CHANNELS];
   chan_status_type status [NUM_CHANNELS];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GAP_REGS; g++) begin
            gap_ff[g] <= DEFAULT_GAP_US;
         end
         trigger_ff  <= 1'b0;
         led_mask_ff <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAP_CH0:  gap_ff[0]   <= csr_write_data[TIME_W-1:0];
            CSR_GAP_CH1:  gap_ff[1]   <= csr_write_data[TIME_W-1:0];
            CSR_GAP_CH2:  gap_ff[2]   <= csr_write_data[TIME_W-1:0];
            CSR_TRIGGER:  trigger_ff  <= csr_write_data[0];
            CSR_LED_MASK: led_mask_ff <= csr_write_data[LED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input register: load on transfer, drain when the item steps out
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff    <= req_type;
         in_channel_ff <= req_channel;
         in_level_ff   <= req_pin_level;
         in_now_ff     <= req_now_us;
      end
   end

   // per-channel control; channels without a gap register use the default,
   // channels without an LED bit never light
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      logic [TIME_W-1:0] gap_sel;
      logic              led_sel;

      if (c < GAP_REGS) begin : g_gap
         assign gap_sel = gap_ff[c];
      end else begin : g_nogap
         assign gap_sel = '0;
      end

      if (c < LED_BITS) begin : g_led
         assign led_sel = led_mask_ff[c];
      end else begin : g_noled
         assign led_sel = 1'b0;
      end

      always_comb begin
         ctl[c].step       = step;
         ctl[c].sample_sel = (in_type_ff == REQ_SAMPLE) && (int'(in_channel_ff) == c);
         ctl[c].clear      = (in_type_ff == REQ_CLEAR);
         ctl[c].level      = in_level_ff;
         ctl[c].trigger    = trigger_ff;
         ctl[c].now        = in_now_ff;
         ctl[c].gap        = gap_sel;
         ctl[c].led_en     = led_sel;
      end

      gic_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[c]),
         .status (status[c])
      );
   end

   // assemble the response from the post-item channel state
   always_comb begin
      rsp_ok_in      = int'(in_channel_ff) < NUM_CHANNELS;
      rsp_count_in   = '0;
      rsp_counted_in = 1'b0;
      rsp_led_in     = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (int'(in_channel_ff) == c) begin
            rsp_count_in = status[c].count;
         end
         rsp_counted_in = rsp_counted_in | status[c].hit;
         if (c < LED_BITS) begin
            rsp_led_in[c] = status[c].led;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_count_ff   <= rsp_count_in;
         rsp_counted_ff <= rsp_counted_in;
         rsp_ok_ff      <= rsp_ok_in;
         rsp_led_ff     <= rsp_led_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_count_ff;
   assign rsp_counted     = rsp_counted_ff;
   assign rsp_channel_ok  = rsp_ok_ff;
   assign rsp_led_lit     = rsp_led_ff;

endmodule

@@ test/gated_impulse_counter_core_test.sv @@
// ----------------------------------------------------------------------------
// gated_impulse_counter_core_test: self-checking bench for the impulse counter
// Drives pin samples, reads, clears and unused request codes through the
// request channel under random idle and stall bursts. Every accepted request
// is run through a behavioral meter model, and each response transfer is
// compared field by field with the oldest predicted reading. Register settings
// change between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module gated_impulse_counter_core_test
   import gic_pkg::*;
();

   // request code the block does not define; it behaves like a read
   localparam logic [TYPE_W-1:0] REQ_UNUSED  = 2'd3;
   // channel number past the last real channel
   localparam logic [CH_W-1:0]   BAD_CHANNEL = 2'd3;
   // generous cap on run time, far above the slowest legal run
   localparam int                RUN_CAP     = 4_000_000;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [CH_W-1:0]   chan;
      logic              level;
      logic [TIME_W-1:0] stamp;
   } meter_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic                counted;
      logic                chan_ok;
      logic [LED_BITS-1:0] leds;
   } meter_rsp_type;

   // -------------------------------------------------------------------------
   // Meter model: holds its own copy of counts, levels, timers, LEDs and the
   // register file, and queues the reading each accepted request must produce.
   // -------------------------------------------------------------------------
   class impulse_book;
      logic [COUNT_W-1:0]      counts [NUM_CHANNELS];
      logic [NUM_CHANNELS-1:0] last_level;
      logic [TIME_W-1:0]       last_change [NUM_CHANNELS];
      logic [TIME_W-1:0]       led_start [NUM_CHANNELS];
      logic [NUM_CHANNELS-1:0] led_on;
      logic [TIME_W-1:0]       gap_reg [GAP_REGS];
      logic                    trigger;
      logic [LED_BITS-1:0]     led_mask;
      meter_rsp_type           awaited_readings [$];
      int                      errors;

      function void power_on();
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            counts[c]      = '0;
            last_change[c] = '0;
            led_start[c]   = '0;
         end
         for (int g = 0; g < GAP_REGS; g++) gap_reg[g] = DEFAULT_GAP_US;
         last_level = '0;
         led_on     = '0;
         trigger    = 1'b0;
         led_mask   = '1;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_W-1:0] idx, logic [CSR_DW-1:0] data);
         case (idx) inside
            CSR_GAP_CH0, CSR_GAP_CH1, CSR_GAP_CH2: gap_reg[idx[1:0]] = data[TIME_W-1:0];
            CSR_TRIGGER:  trigger  = data[0];
            CSR_LED_MASK: led_mask = data[LED_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited_readings.size();
      endfunction

      // Advance the model by one accepted request and queue its reading.
      function void book_request(meter_req_type r);
         meter_rsp_type     e;
         logic [TIME_W-1:0] elapsed;
         logic [TIME_W-1:0] need;
         int                ch;
         bit                ok;
         ch = int'(r.chan);
         ok = ch < NUM_CHANNELS;
         e.counted = 1'b0;
         // expire LEDs first, whatever the request is
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            elapsed = r.stamp - led_start[c];
            if (led_on[c] && elapsed >= LED_PULSE_US) led_on[c] = 1'b0;
         end
         if (r.kind == REQ_SAMPLE && ok) begin
            if (r.level != last_level[ch]) begin
               need = DEFAULT_GAP_US;
               if (ch < GAP_REGS && gap_reg[ch] != '0) need = gap_reg[ch];
               elapsed = r.stamp - last_change[ch];
               if (r.level == trigger && elapsed >= need) begin
                  counts[ch] = counts[ch] + 1'b1;
                  e.counted  = 1'b1;
                  if (ch < LED_BITS && led_mask[ch]) begin
                     led_on[ch]    = 1'b1;
                     led_start[ch] = r.stamp;
                  end
               end
               last_level[ch]  = r.level;
               last_change[ch] = r.stamp;
            end
         end else if (r.kind == REQ_CLEAR) begin
            for (int c = 0; c < NUM_CHANNELS; c++) counts[c] = '0;
         end
         e.count   = ok ? counts[ch] : '0;
         e.chan_ok = ok;
         e.leds    = '0;
         for (int c = 0; c < NUM_CHANNELS && c < LED_BITS; c++) e.leds[c] = led_on[c];
         awaited_readings.push_back(e);
      endfunction

      // Compare one response transfer with the oldest queued reading.
      function void match_response(meter_rsp_type got);
         meter_rsp_type want;
         if (awaited_readings.size() == 0) begin
            $display("%0t: response with nothing outstanding: count %h", $time, got.count);
            errors++;
            return;
         end
         want = awaited_readings.pop_front();
         if (got.count !== want.count) begin
            $display("%0t: count_value expected %h actual %h", $time, want.count, got.count);
            errors++;
         end
         if (got.counted !== want.counted) begin
            $display("%0t: counted expected %b actual %b", $time, want.counted, got.counted);
            errors++;
         end
         if (got.chan_ok !== want.chan_ok) begin
            $display("%0t: channel_ok expected %b actual %b", $time, want.chan_ok, got.chan_ok);
            errors++;
         end
         if (got.leds !== want.leds) begin
            $display("%0t: led_lit expected %b actual %b", $time, want.leds, got.leds);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [TYPE_W-1:0]   req_type;
   logic [CH_W-1:0]     req_channel;
   logic                req_pin_level;
   logic [TIME_W-1:0]   req_now_us;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COUNT_W-1:0]  rsp_count_value;
   logic                rsp_counted;
   logic                rsp_channel_ok;
   logic [LED_BITS-1:0] rsp_led_lit;
   logic                csr_write_enable;
   logic [CSR_W-1:0]    csr_index;
   logic [CSR_DW-1:0]   csr_write_data;

   impulse_book         book;
   bit                  calm = 1'b0;   // no idling on either side when set
   int                  hold_left = 0; // cycles left in the current stall or run burst
   logic [TIME_W-1:0]   wall_us;       // running timestamp for random traffic
   logic [3:0]          pin_seen;      // last level sent per channel number

   gated_impulse_counter_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_channel      (req_channel),
      .req_pin_level    (req_pin_level),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_value  (rsp_count_value),
      .rsp_counted      (rsp_counted),
      .rsp_channel_ok   (rsp_channel_ok),
      .rsp_led_lit      (rsp_led_lit),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stall and run bursts; run bursts are sometimes long
   // so the block also sees stretches of full throughput.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         hold_left = $urandom_range(1, 19);
      end else begin
         rsp_stall <= 1'b0;
         hold_left = $urandom_range(1, 40);
      end
   end

   // Response watch: a transfer happens where valid is high and stall is low.
   always @(posedge clock) begin : rsp_watch
      meter_rsp_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.count   = rsp_count_value;
         seen.counted = rsp_counted;
         seen.chan_ok = rsp_channel_ok;
         seen.leds    = rsp_led_lit;
         book.match_response(seen);
      end
   end

   // Present one request, hold it until the transfer, then book it.
   task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [CH_W-1:0] chan,
                            input logic level, input logic [TIME_W-1:0] stamp);
      meter_req_type item;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      item          = '{kind, chan, level, stamp};
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_channel   <= chan;
      req_pin_level <= level;
      req_now_us    <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.book_request(item);
   endtask

   // Drop valid and wait until every booked reading has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      book.set_reg(idx, data);
      @(posedge clock);
   endtask

   // Load the whole register file; call only while the block is idle.
   task automatic load_settings(input logic [TIME_W-1:0] gap0, input logic [TIME_W-1:0] gap1,
                                input logic [TIME_W-1:0] gap2, input logic trig,
                                input logic [LED_BITS-1:0] mask);
      write_reg(CSR_GAP_CH0, CSR_DW'(gap0));
      write_reg(CSR_GAP_CH1, CSR_DW'(gap1));
      write_reg(CSR_GAP_CH2, CSR_DW'(gap2));
      write_reg(CSR_TRIGGER, CSR_DW'(trig));
      write_reg(CSR_LED_MASK, CSR_DW'(mask));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Zero stands for the default gap; the rest spans short, typical and huge.
   function automatic logic [TIME_W-1:0] pick_gap();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return $urandom_range(1, 80000);
         2:       return $urandom_range(1, 200000);
         default: return $urandom;
      endcase
   endfunction

   // Random traffic: mostly pin samples that toggle a channel's level with
   // time moving forward around the gap and LED pulse lengths, plus reads,
   // clears, unused codes, bad channels and timestamp jumps.
   task automatic run_random(input int n);
      logic [TYPE_W-1:0] kind;
      logic [CH_W-1:0]   chan;
      logic              level;
      int                pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 72)      kind = REQ_SAMPLE;
         else if (pick < 85) kind = REQ_READ;
         else if (pick < 90) kind = REQ_CLEAR;
         else if (pick < 94) kind = REQ_UNUSED;
         else                kind = TYPE_W'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) chan = BAD_CHANNEL;
         else                           chan = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
         pick = $urandom_range(0, 19);
         if (pick == 0)     wall_us = $urandom;
         else if (pick < 4) wall_us = wall_us + $urandom_range(50000, 160000);
         else               wall_us = wall_us + $urandom_range(0, 30000);
         if (kind == REQ_SAMPLE && $urandom_range(0, 6) != 0) level = ~pin_seen[chan];
         else                                                  level = 1'($urandom_range(0, 1));
         if (kind == REQ_SAMPLE) pin_seen[chan] = level;
         send_item(kind, chan, level, wall_us);
      end
   endtask

   initial begin
      book = new;
      book.power_on();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_READ;
      req_channel      = '0;
      req_pin_level    = 1'b0;
      req_now_us       = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_GAP_CH0;
      csr_write_data   = '0;
      wall_us          = '0;
      pin_seen         = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: 50000 us gap, trigger on low, all LEDs on.
      send_item(REQ_READ, 2'd0, 1'b0, 32'd0);
      send_item(REQ_SAMPLE, 2'd0, 1'b1, 32'd10);        // rise to non-trigger level
      send_item(REQ_SAMPLE, 2'd0, 1'b0, 32'd50010);     // exactly the gap: count
      send_item(REQ_SAMPLE, 2'd1, 1'b1, 32'd50020);
      send_item(REQ_SAMPLE, 2'd1, 1'b0, 32'd50030);     // too soon after change
      send_item(REQ_SAMPLE, 2'd0, 1'b0, 32'd60000);     // no level change
      send_item(REQ_READ, BAD_CHANNEL, 1'b0, 32'd70000);
      send_item(REQ_SAMPLE, BAD_CHANNEL, 1'b1, 32'd80000);
      send_item(REQ_READ, 2'd0, 1'b0, 32'd150009);      // LED one short of expiry
      send_item(REQ_READ, 2'd0, 1'b0, 32'd150010);      // LED pulse just over
      send_item(REQ_SAMPLE, 2'd2, 1'b1, 32'hFFFF_FFFF);
      send_item(REQ_SAMPLE, 2'd2, 1'b0, 32'hFFFF_FFFF); // same timestamp, no count
      send_item(REQ_CLEAR, BAD_CHANNEL, 1'b0, 32'h8000_0000);
      send_item(REQ_READ, 2'd0, 1'b1, 32'h8000_0001);
      send_item(REQ_UNUSED, 2'd1, 1'b1, 32'h8000_0002);
      settle();

      // Directed, edge settings: zero gap falls back to the default, one
      // microsecond gap, full-range gap, trigger on high, only LED 1 enabled.
      load_settings(32'd0, 32'd1, 32'hFFFF_FFFF, 1'b1, 3'b010);
      send_item(REQ_SAMPLE, 2'd0, 1'b1, 32'h8001_0000);
      send_item(REQ_SAMPLE, 2'd1, 1'b1, 32'h8001_0001);
      send_item(REQ_SAMPLE, 2'd1, 1'b0, 32'h8001_0002);
      send_item(REQ_SAMPLE, 2'd1, 1'b1, 32'h8001_0003); // one microsecond apart
      send_item(REQ_SAMPLE, 2'd2, 1'b1, 32'hFFFF_FFFE); // wrapped elapsed equals gap
      send_item(REQ_CLEAR, 2'd1, 1'b0, 32'hFFFF_FFFF);
      send_item(REQ_READ, 2'd2, 1'b0, 32'd0);
      settle();

      // Random phases, each under its own register setting; the last one
      // runs without idling on either side.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       load_settings(32'd1, 32'd1, 32'd1, 1'b1, 3'b111);
            1:       load_settings(32'hFFFF_FFFF, 32'd100000, 32'd1, 1'b0, 3'b000);
            default: load_settings(pick_gap(), pick_gap(), pick_gap(),
                                   1'($urandom_range(0, 1)),
                                   LED_BITS'($urandom_range(0, 7)));
         endcase
         calm = (phase == 5);
         run_random(160);
         settle();
      end

      if (book.errors == 0) begin
         $display("[gated_impulse_counter_core] OK");
      end else begin
         $display("[gated_impulse_counter_core] ERROR");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(RUN_CAP);
      $display("[gated_impulse_counter_core] ERROR");
      $finish;
   end

endmodule

@@ gated_impulse_counter_core.f @@
hdl/gic_pkg.sv
hdl/gic_channel.sv
hdl/gated_impulse_counter_core.sv
test/gated_impulse_counter_core_test.sv
